### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next clock cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/pmmr_pkg.sv
// Package for the PS/2 mouse motion reporter: codes, widths, knock table.
// No dependencies.
`timescale 1ns / 1ps

package pmmr_pkg;

  // operation codes (in_tuser)
  localparam logic [1:0] OP_MOTION = 2'd0;
  localparam logic [1:0] OP_HOST   = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  // register indexes (byte address 4*i)
  localparam logic [1:0] REG_RESOLUTION = 2'd0;
  localparam logic [1:0] REG_REPORT_EN  = 2'd1;
  localparam logic [1:0] REG_STREAM     = 2'd2;

  // protocol IDs
  localparam logic [2:0] PROTO_STD   = 3'd0;
  localparam logic [2:0] PROTO_WHEEL = 3'd3;
  localparam logic [2:0] PROTO_FIVE  = 3'd4;

  // knock sequence positions
  localparam logic [3:0] KNOCK_HALF = 4'd6;
  localparam logic [3:0] KNOCK_FULL = 4'd12;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef logic [7:0] byte_t;

  // Expected host byte at each knock position.
  function automatic byte_t knock_byte(input logic [3:0] pos);
    byte_t b;
    unique case (pos)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10: b = 8'hf3;
      4'd1, 4'd7, 4'd9:                    b = 8'hc8;
      4'd3:                                b = 8'h64;
      4'd5, 4'd11:                         b = 8'h50;
      default:                             b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/ps2_mouse_motion_reporter.sv
// PS/2 mouse motion reporter, device side, with wheel and five-button packets.
// Depends on pmmr_pkg.
`timescale 1ns / 1ps

//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser: operation; tdata: moves, buttons, host byte
//  out_    | out | out_tvalid/tready  | tdata: packet byte, byte index; tlast: last byte
//  cfg_    | in  | APB, pready tied 1 | resolution, reporting enable, stream mode
//
//  Items land in an input register and are worked on from there.
//  Motion and host items never wait on the output side.
//  A report that emits loads a 4-byte packet buffer and drains 3 or 4 bytes from it,
//  one byte per cycle while out_tready is high; the next report loads once busy clears.
//  A report arriving while the buffer still drains holds in the input register.
//  rst_n is synchronous; it clears the mouse and control state and restores register defaults.

module ps2_mouse_motion_reporter
  import pmmr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] move_x, [31:16] move_y, [39:32] move_z, [44:40] button_bits,
  // [52:45] host_byte, [55:53] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  logic [1:0]            in_tuser,
  // result items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] packet_byte, [9:8] byte_index, [15:10] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // ---------------- configuration registers ----------------
  logic [1:0] res_r;
  logic       rep_en_r;
  logic       stream_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r    <= 2'd2;
      rep_en_r <= 1'b0;
      stream_r <= 1'b1;
    end else if (cfg_wr) begin
      priority case (cfg_idx)
        REG_RESOLUTION: res_r    <= cfg_pwdata[1:0];
        REG_REPORT_EN:  rep_en_r <= cfg_pwdata[0];
        REG_STREAM:     stream_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    priority case (cfg_idx)
      REG_RESOLUTION: cfg_prdata[1:0] = res_r;
      REG_REPORT_EN:  cfg_prdata[0]   = rep_en_r;
      REG_STREAM:     cfg_prdata[0]   = stream_r;
      default: ;
    endcase
  end

  // ---------------- input register ----------------
  logic                 in_vld_r;
  logic [IN_DATA_W-1:0] in_data_r;
  logic [1:0]           in_op_r;
  logic                 advance;

  // mouse state
  logic [15:0] ax_r, ax_nxt;
  logic [15:0] ay_r, ay_nxt;
  logic [7:0]  az_r, az_nxt;
  logic [4:0]  btn_r, btn_nxt;
  logic        pend_r, pend_nxt;
  logic [2:0]  proto_r, proto_nxt;
  logic [3:0]  kpos_r, kpos_nxt;

  // packet buffer, head drives the output
  byte_t       pkt_r [4];
  byte_t       pkt_nxt [4];
  logic [1:0]  idx_r, idx_nxt;
  logic [1:0]  last_r, last_nxt;
  logic        busy_r, busy_nxt;

  // unpacked fields of the held item
  logic [15:0] mx, my;
  logic [7:0]  mz, hb;
  logic [4:0]  mb;
  logic        honored;

  assign mx = in_data_r[15:0];
  assign my = in_data_r[31:16];
  assign mz = in_data_r[39:32];
  assign mb = in_data_r[44:40];
  assign hb = in_data_r[52:45];

  assign honored = stream_r & rep_en_r & pend_r;
  // only an emitting report needs the buffer; everything else always moves on
  assign advance   = in_vld_r & ~((in_op_r == OP_REPORT) & honored & busy_r);
  assign in_tready = ~in_vld_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
      in_op_r   <= in_tuser;
    end
  end

  // ---------------- packet assembly ----------------
  logic [1:0]  sh;
  logic [15:0] sx, sy, keep;
  byte_t       b0, b3;
  logic        has_b3;

  assign sh   = 2'd3 - res_r;
  assign sx   = 16'($signed(ax_r) >>> sh);
  assign sy   = 16'($signed(ay_r) >>> sh);
  assign keep = ~(16'hffff << sh);   // remainder bits kept after a report
  assign b0   = {2'b00, sy[8], sx[8], 1'b1, btn_r[2:0]};
  assign has_b3 = (proto_r == PROTO_WHEEL) || (proto_r == PROTO_FIVE);
  assign b3   = (proto_r == PROTO_FIVE) ? {2'b00, btn_r[4:3], az_r[3:0]} : az_r;

  // ---------------- knock sequence ----------------
  logic [3:0] kbase, kinc;
  logic       khit;

  assign kbase = (kpos_r >= KNOCK_FULL) ? 4'd0 : kpos_r;
  assign khit  = (hb == knock_byte(kbase));
  assign kinc  = kbase + 4'd1;

  // ---------------- next state ----------------
  logic out_take;
  assign out_take = busy_r & out_tready;

  always_comb begin
    ax_nxt    = ax_r;
    ay_nxt    = ay_r;
    az_nxt    = az_r;
    btn_nxt   = btn_r;
    pend_nxt  = pend_r;
    proto_nxt = proto_r;
    kpos_nxt  = kpos_r;
    pkt_nxt   = pkt_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    busy_nxt  = busy_r;

    if (out_take) begin
      if (idx_r == last_r) busy_nxt = 1'b0;
      else                 idx_nxt  = idx_r + 2'd1;
    end

    if (advance) begin
      priority case (in_op_r)
        OP_MOTION: begin
          ax_nxt   = ax_r + mx;
          ay_nxt   = ay_r + my;
          az_nxt   = az_r + mz;
          btn_nxt  = mb;
          pend_nxt = 1'b1;
        end
        OP_HOST: begin
          if (khit) begin
            kpos_nxt = kinc;
            if (kinc == KNOCK_HALF) begin
              proto_nxt = PROTO_WHEEL;
            end else if (kinc == KNOCK_FULL) begin
              proto_nxt = PROTO_FIVE;
              kpos_nxt  = KNOCK_HALF;
            end
          end else begin
            kpos_nxt = (kbase < KNOCK_HALF) ? 4'd0 : KNOCK_HALF;
          end
        end
        OP_REPORT: begin
          // buffer is free here: advance holds an emitting report while busy
          if (honored) begin
            pkt_nxt[0] = b0;
            pkt_nxt[1] = sx[7:0];
            pkt_nxt[2] = sy[7:0];
            pkt_nxt[3] = b3;
            last_nxt   = has_b3 ? 2'd3 : 2'd2;
            idx_nxt    = 2'd0;
            busy_nxt   = 1'b1;
            ax_nxt     = ax_r & keep;
            ay_nxt     = ay_r & keep;
            az_nxt     = 8'd0;
            pend_nxt   = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r    <= '0;
      ay_r    <= '0;
      az_r    <= '0;
      btn_r   <= '0;
      pend_r  <= 1'b0;
      proto_r <= PROTO_STD;
      kpos_r  <= '0;
      busy_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      ax_r    <= ax_nxt;
      ay_r    <= ay_nxt;
      az_r    <= az_nxt;
      btn_r   <= btn_nxt;
      pend_r  <= pend_nxt;
      proto_r <= proto_nxt;
      kpos_r  <= kpos_nxt;
      busy_r  <= busy_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pkt_r  <= pkt_nxt;
    last_r <= last_nxt;
  end

  // ---------------- output ----------------
  assign out_tvalid = busy_r;
  assign out_tdata  = {6'd0, idx_r, pkt_r[idx_r]};
  assign out_tlast  = (idx_r == last_r);

endmodule

### rtl/core/pmmr_checker.sv
// Port-level checks for the PS/2 mouse motion reporter, bound to the top level.
// Depends on pmmr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pmmr_checker
  import pmmr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // stalled item holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "out item changed while stalled")

  // packet bytes come in order with no gap in the index
  `ASSERT_NEXT(a_idx_step, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid && (out_tdata[9:8] == $past(out_tdata[9:8]) + 2'd1), "byte index did not step")

  // first byte always carries the sync bit and is never the last
  `ASSERT_IMPL(a_sync_bit, clk, rst_n, out_tvalid && (out_tdata[9:8] == 2'd0), out_tdata[3] && !out_tlast, "bad first packet byte")

  // a packet ends on its third or fourth byte
  `ASSERT_IMPL(a_last_pos, clk, rst_n, out_tvalid && out_tlast, (out_tdata[9:8] == 2'd2) || (out_tdata[9:8] == 2'd3), "packet ends at wrong byte")

endmodule

bind ps2_mouse_motion_reporter pmmr_checker u_pmmr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### bench/testbench.sv
// Self-checking bench for ps2_mouse_motion_reporter: directed table, then random phases.
// Depends on pmmr_pkg and the reporter RTL; packet bytes are checked against a local predictor.
`timescale 1ns / 1ps

module testbench;
  import pmmr_pkg::*;

  // idle cycles with no item moved on either side before the run is abandoned
  localparam int STALL_LIMIT  = 1000;
  // cycles to let a motion or host item still in the input register finish
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEM_TARGET  = 410;

  // one stimulus row: either an input item or a register write
  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  op;
    logic [15:0] mx;
    logic [15:0] my;
    logic [7:0]  mz;
    logic [4:0]  btn;
    logic [7:0]  hb;
    logic        has_typed;   // expected packet typed in by hand
    logic [2:0]  typed_len;
    logic [3:0][7:0] typed;   // byte k at typed[k]
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] pkt;
    logic [1:0] idx;
    logic       last;
  } pkt_byte_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  ps2_mouse_motion_reporter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Mouse model: register copies and device state, reset values
  // ---------------------------------------------------------------------------
  logic [1:0]  res_cfg    = 2'd2;
  logic        en_cfg     = 1'b0;
  logic        stream_cfg = 1'b1;
  logic [15:0] acc_x      = '0;
  logic [15:0] acc_y      = '0;
  logic [7:0]  acc_z      = '0;
  logic [4:0]  btns       = '0;
  logic        pending    = 1'b0;
  logic [2:0]  proto      = PROTO_STD;
  logic [3:0]  knock_pos  = '0;

  // sample-rate knocks: first half selects wheel, second half five-button
  logic [7:0] knock_seq [12] = '{8'hf3, 8'hc8, 8'hf3, 8'h64, 8'hf3, 8'h50,
                                 8'hf3, 8'hc8, 8'hf3, 8'hc8, 8'hf3, 8'h50};

  pkt_byte_t packet_q [$];   // packet bytes still owed by the block
  stim_row_t table_q [$];    // directed rows
  logic [7:0] host_q [$];    // queued host bytes of a knock burst
  int        failures = 0;
  int        idle_cycles = 0;
  int        item_count = 0;
  bit        quiet = 1'b0;   // no gaps or stalls on either side
  pkt_byte_t head;

  // Applies one item to the mouse model; returns the packet length (0 if none).
  function automatic int mouse_step(input stim_row_t r, output logic [3:0][7:0] pkt);
    int          n;
    logic [3:0]  pos;
    logic [1:0]  sh;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] keep;
    n   = 0;
    pkt = '0;
    case (r.op)
      OP_MOTION: begin
        acc_x   = acc_x + r.mx;
        acc_y   = acc_y + r.my;
        acc_z   = acc_z + r.mz;
        btns    = r.btn;
        pending = 1'b1;
      end
      OP_HOST: begin
        pos = knock_pos;
        if (pos >= KNOCK_FULL) pos = 4'd0;
        if (r.hb == knock_seq[pos]) begin
          pos = pos + 4'd1;
          if (pos == KNOCK_HALF) begin
            proto = PROTO_WHEEL;
          end else if (pos == KNOCK_FULL) begin
            proto = PROTO_FIVE;
            pos   = KNOCK_HALF;
          end
        end else begin
          // a miss falls back to the start of the current half
          pos = (pos < KNOCK_HALF) ? 4'd0 : KNOCK_HALF;
        end
        knock_pos = pos;
      end
      OP_REPORT: begin
        if (stream_cfg && en_cfg && pending) begin
          sh   = 2'd3 - res_cfg;
          sx   = $signed(acc_x) >>> sh;
          sy   = $signed(acc_y) >>> sh;
          keep = (16'd1 << sh) - 16'd1;
          pkt[0] = {2'b00, sy[8], sx[8], 1'b1, btns[2:0]};
          pkt[1] = sx[7:0];
          pkt[2] = sy[7:0];
          n = 3;
          if (proto == PROTO_FIVE) begin
            pkt[3] = {2'b00, btns[4:3], acc_z[3:0]};
            n = 4;
          end else if (proto == PROTO_WHEEL) begin
            pkt[3] = acc_z;
            n = 4;
          end
          // shifted-out bits stay behind as remainder
          acc_x   = acc_x & keep;
          acc_y   = acc_y & keep;
          acc_z   = '0;
          pending = 1'b0;
        end
      end
      default: ;  // unused code: ignored
    endcase
    return n;
  endfunction

  function automatic stim_row_t item_row(input logic [1:0] op, input logic [15:0] mx,
                                         input logic [15:0] my, input logic [7:0] mz,
                                         input logic [4:0] btn, input logic [7:0] hb);
    stim_row_t r;
    r        = '0;
    r.op     = op;
    r.mx     = mx;
    r.my     = my;
    r.mz     = mz;
    r.btn    = btn;
    r.hb     = hb;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input stim_row_t r, input logic [2:0] len,
                                          input logic [3:0][7:0] pkt);
    stim_row_t t;
    t           = r;
    t.has_typed = 1'b1;
    t.typed_len = len;
    t.typed     = pkt;
    return t;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
    stim_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Fully random fields; only the operation is chosen by the caller.
  function automatic stim_row_t random_row(input logic [1:0] op);
    logic [15:0] mx;
    logic [15:0] my;
    logic [7:0]  mz;
    // half the moves are small so remainders and sign flips show up often
    mx = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 64) - 32);
    my = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 64) - 32);
    mz = ($urandom_range(0, 1) != 0) ? 8'($urandom)  : 8'($urandom_range(0, 16) - 8);
    return item_row(op, mx, my, mz, 5'($urandom), 8'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Every task starts and ends at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic drain_wait();
    in_tvalid = 1'b0;
    while (packet_q.size() != 0) @(posedge clk);
    // a motion or host item may still sit in the input register
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_RESOLUTION: res_cfg    = val[1:0];
      REG_REPORT_EN:  en_cfg     = val[0];
      REG_STREAM:     stream_cfg = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic send_item(input stim_row_t r);
    int gap;
    int n;
    logic [3:0][7:0] pkt;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = r.op;
    in_tdata  = {3'b000, r.hb, r.btn, r.mz, r.my, r.mx};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    item_count++;
    n = mouse_step(r, pkt);
    if (r.has_typed) begin
      n   = int'(r.typed_len);
      pkt = r.typed;
    end
    for (int k = 0; k < n; k++) packet_q.push_back('{pkt[2'(k)], 2'(k), k == n - 1});
    // valid stays high; the next call lowers it only if it draws a gap
    @(negedge clk);
  endtask

  task automatic run_row(input stim_row_t r);
    if (r.is_cfg) begin
      drain_wait();
      reg_write(r.reg_idx, r.reg_val);
    end else begin
      send_item(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall before each byte, then ready until it moves
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (packet_q.size() == 0) begin
        $error("packet byte %h with nothing expected", out_tdata[7:0]);
        failures++;
      end else begin
        head = packet_q.pop_front();
        if (out_tdata[7:0] !== head.pkt) begin
          $error("packet_byte: expected %h, got %h", head.pkt, out_tdata[7:0]);
          failures++;
        end
        if (out_tdata[9:8] !== head.idx) begin
          $error("byte_index: expected %0d, got %0d", head.idx, out_tdata[9:8]);
          failures++;
        end
        if (out_tlast !== head.last) begin
          $error("last_byte: expected %b, got %b", head.last, out_tlast);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $error("no progress for %0d cycles, %0d bytes outstanding", STALL_LIMIT,
             packet_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int r;
    int len;
    stim_row_t row;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_MOTION;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows. After reset reporting is off, so a request gives nothing.
    table_q.push_back(typed_row(item_row(OP_REPORT, 16'h0, 16'h0, 8'h0, 5'h0, 8'h0),
                                3'd0, '0));
    table_q.push_back(item_row(OP_MOTION, 16'h7fff, 16'h8000, 8'h7f, 5'h1f, 8'h00));
    table_q.push_back(cfg_row(REG_RESOLUTION, 32'd3));
    table_q.push_back(cfg_row(REG_REPORT_EN, 32'd1));
    // no shift: X max sets the X sign bit, Y min leaves low bytes zero
    table_q.push_back(typed_row(item_row(OP_REPORT, 16'h0, 16'h0, 8'h0, 5'h0, 8'hff),
                                3'd3, {8'h00, 8'h00, 8'hff, 8'h1f}));
    // nothing pending now
    table_q.push_back(typed_row(item_row(OP_REPORT, 16'hffff, 16'hffff, 8'hff, 5'h1f,
                                         8'hff), 3'd0, '0));
    // unused operation code
    table_q.push_back(typed_row(item_row(2'd3, 16'h1234, 16'h5678, 8'h9a, 5'h15, 8'hf3),
                                3'd0, '0));
    table_q.push_back(cfg_row(REG_RESOLUTION, 32'd0));
    table_q.push_back(item_row(OP_MOTION, 16'h8000, 16'h7fff, 8'h80, 5'h00, 8'h00));
    // shift by three: remainder 7 stays in Y
    table_q.push_back(typed_row(item_row(OP_REPORT, 16'h0, 16'h0, 8'h0, 5'h0, 8'h0),
                                3'd3, {8'h00, 8'hff, 8'h00, 8'h28}));
    // broken knock, then the wheel knock
    table_q.push_back(item_row(OP_HOST, 16'h0, 16'h0, 8'h0, 5'h0, 8'hf3));
    table_q.push_back(item_row(OP_HOST, 16'h0, 16'h0, 8'h0, 5'h0, 8'h00));
    for (int k = 0; k < 6; k++)
      table_q.push_back(item_row(OP_HOST, 16'h0, 16'h0, 8'h0, 5'h0, knock_seq[4'(k)]));
    table_q.push_back(item_row(OP_MOTION, 16'd5, 16'hfffd, 8'hff, 5'h1a, 8'h00));
    table_q.push_back(item_row(OP_REPORT, 16'h0, 16'h0, 8'h0, 5'h0, 8'h0));
    // five-button knock
    for (int k = 6; k < 12; k++)
      table_q.push_back(item_row(OP_HOST, 16'h0, 16'h0, 8'h0, 5'h0, knock_seq[4'(k)]));
    table_q.push_back(item_row(OP_MOTION, 16'hfff0, 16'd9, 8'h0b, 5'h1f, 8'h00));
    table_q.push_back(item_row(OP_REPORT, 16'h0, 16'h0, 8'h0, 5'h0, 8'h0));

    foreach (table_q[i]) run_row(table_q[i]);

    // Random phases: settings change only once the block has gone idle.
    for (int p = 0; item_count < ITEM_TARGET; p++) begin
      drain_wait();
      quiet = (p % 4 == 1);
      case (p)
        0: begin
          reg_write(REG_RESOLUTION, 32'd0);
          reg_write(REG_REPORT_EN, 32'd1);
          reg_write(REG_STREAM, 32'd1);
        end
        1: reg_write(REG_RESOLUTION, 32'd3);
        2: reg_write(REG_REPORT_EN, 32'd0);
        3: begin
          reg_write(REG_REPORT_EN, 32'd1);
          reg_write(REG_STREAM, 32'd0);
        end
        default: begin
          reg_write(REG_RESOLUTION, 32'($urandom_range(0, 3)));
          reg_write(REG_REPORT_EN, 32'($urandom_range(0, 5) != 0));
          reg_write(REG_STREAM, 32'($urandom_range(0, 5) != 0));
        end
      endcase

      for (int i = 0; i < 38 && item_count < ITEM_TARGET; i++) begin
        if (host_q.size() != 0) begin
          row    = random_row(OP_HOST);
          row.hb = host_q.pop_front();
          send_item(row);
          continue;
        end
        r = $urandom_range(0, 99);
        if (r < 32) begin
          send_item(random_row(OP_MOTION));
        end else if (r < 64) begin
          send_item(random_row(OP_REPORT));
        end else if (r < 68) begin
          send_item(random_row(2'd3));
        end else if (r < 71) begin
          // hold the sender until every owed byte has come out
          drain_wait();
        end else if (p >= 3 && $urandom_range(0, 2) != 0) begin
          // knock burst: wheel, five-button, or a five-button prefix cut short
          case ($urandom_range(0, 2))
            0: for (int k = 0; k < 6; k++) host_q.push_back(knock_seq[4'(k)]);
            1: for (int k = 6; k < 12; k++) host_q.push_back(knock_seq[4'(k)]);
            default: begin
              len = $urandom_range(1, 5);
              for (int k = 6; k < 6 + len; k++) host_q.push_back(knock_seq[4'(k)]);
              host_q.push_back(8'($urandom));
            end
          endcase
        end else begin
          send_item(random_row(OP_HOST));
        end
      end
    end

    host_q.delete();
    drain_wait();
    if (failures == 0 && packet_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### ps2_mouse_motion_reporter.f
+incdir+rtl/core
rtl/core/pmmr_pkg.sv
rtl/core/ps2_mouse_motion_reporter.sv
rtl/core/pmmr_checker.sv
bench/testbench.sv
